// ===== design/nplut_pkg.sv =====
// nplut_pkg: shared types and constants of the nearest palette colour lookup
// used by nplut_cell and nearest_palette_colour_lut_top; no dependencies
package nplut_pkg;

    localparam int MAX_COLOURS_DEF = 256;
    localparam int GRID_SHIFT      = 4;
    localparam int CHAN_W          = 8;
    localparam int COLOUR_W        = 3 * CHAN_W;
    localparam int DIST_W          = 18;
    localparam int NUM_CELLS       = 3;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } scan_ctl_t;

endpackage

// ===== design/nplut_cell.sv =====
// nplut_cell: one distance cell of the scan chain, adds the squared
// difference of one channel and passes the colour on rotated by one channel
// depends on nplut_pkg
module nplut_cell
    import nplut_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [CHAN_W-1:0]   point,
    input  scan_ctl_t           in_ctl,
    input  logic [IDX_W-1:0]    in_idx,
    input  logic [COLOUR_W-1:0] in_colour,
    input  logic [DIST_W-1:0]   in_dist,
    output scan_ctl_t           out_ctl,
    output logic [IDX_W-1:0]    out_idx,
    output logic [COLOUR_W-1:0] out_colour,
    output logic [DIST_W-1:0]   out_dist
);

    logic [CHAN_W-1:0]   point_reg;
    scan_ctl_t           ctl_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic [CHAN_W-1:0]   chan;
    logic [CHAN_W-1:0]   diff;
    logic [2*CHAN_W-1:0] sq;
    logic [DIST_W-1:0]   dist_next;

    always_comb begin
        chan      = in_colour[COLOUR_W-1 -: CHAN_W];
        diff      = (chan > point_reg) ? chan - point_reg : point_reg - chan;
        sq        = diff * diff;
        dist_next = in_dist + DIST_W'(sq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= in_ctl;
        end
        if (load) begin
            point_reg <= point;
        end
        idx_reg    <= in_idx;
        colour_reg <= {in_colour[COLOUR_W-CHAN_W-1:0], chan};
        dist_reg   <= dist_next;
    end

    assign out_ctl    = ctl_reg;
    assign out_idx    = idx_reg;
    assign out_colour = colour_reg;
    assign out_dist   = dist_reg;

endmodule

// ===== design/nearest_palette_colour_lut_top.sv =====
// nearest_palette_colour_lut_top: palette store, scan sequencer, cell chain
// and nearest-match tracker with a registered result channel
// depends on nplut_pkg and nplut_cell
//
//  channel | dir | tdata fields (low bit up)                     | tuser
//  s_      | in  | red, green, blue, cell_red, cell_green, cell_blue | operation
//  m_      | out | match_index, match_red, match_green, match_blue,  | status
//          |     | table_x, table_y                                  |
//
// clear, append and unused codes go straight to the result state, and their
// result is registered into the output once the output register is free; a
// query on n stored colours streams them from the palette memory read port,
// which delivers one entry per cycle into the three-cell distance chain, and
// its result follows once the last entry has left the chain.
// reset empties the palette at once; no clearing pass is needed.
// one item is worked on at a time; the next transfer is taken as soon as the
// previous result sits in the output register, stalled or not.
module nearest_palette_colour_lut_top
    import nplut_pkg::*;
#(
    parameter int MAX_COLOURS = MAX_COLOURS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // red, green, blue, cell_red, cell_green, cell_blue
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // match_index, match_red, match_green, match_blue,
                                   // table_x, table_y
    output logic [1:0]  m_tuser    // status
);

    localparam int IDX_W = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;
    localparam int CNT_W = $clog2(MAX_COLOURS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // input fields
    logic [1:0]  in_op;
    logic [7:0]  in_red, in_green, in_blue;
    logic [3:0]  in_cr, in_cg, in_cb;

    assign in_op    = s_tuser;
    assign in_red   = s_tdata[7:0];
    assign in_green = s_tdata[15:8];
    assign in_blue  = s_tdata[23:16];
    assign in_cr    = s_tdata[27:24];
    assign in_cg    = s_tdata[31:28];
    assign in_cb    = s_tdata[35:32];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                first_reg, first_next;
    logic [DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [COLOUR_W-1:0] best_col_reg, best_col_next;
    logic [1:0]          res_stat_reg, res_stat_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [COLOUR_W-1:0] res_col_reg, res_col_next;
    logic [5:0]          res_x_reg, res_x_next;
    logic [5:0]          res_y_reg, res_y_next;
    logic                m_valid_reg, m_valid_next;
    logic [47:0]         m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;

    logic                accept;
    logic                issue;
    logic                issue_last;
    logic                wr_en;
    logic                load;
    logic                better;

    // palette memory
    logic [COLOUR_W-1:0] mem [MAX_COLOURS];
    logic [COLOUR_W-1:0] rd_data_reg;
    scan_ctl_t           rd_ctl_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    // cell chain
    scan_ctl_t           ch_ctl    [NUM_CELLS+1];
    logic [IDX_W-1:0]    ch_idx    [NUM_CELLS+1];
    logic [COLOUR_W-1:0] ch_colour [NUM_CELLS+1];
    logic [DIST_W-1:0]   ch_dist   [NUM_CELLS+1];
    logic [CHAN_W-1:0]   pt        [NUM_CELLS];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (in_op == OP_APPEND) && (count_reg != CNT_W'(MAX_COLOURS));
    assign load     = accept && (in_op == OP_QUERY);
    assign issue    = (state_reg == ST_ISSUE);
    assign issue_last = issue && (CNT_W'(addr_reg) == count_reg - CNT_W'(1));

    assign pt[0] = CHAN_W'(in_cr) << GRID_SHIFT;
    assign pt[1] = CHAN_W'(in_cg) << GRID_SHIFT;
    assign pt[2] = CHAN_W'(in_cb) << GRID_SHIFT;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= {in_red, in_green, in_blue};
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
        if (!aresetn) begin
            rd_ctl_reg <= '0;
        end else begin
            rd_ctl_reg <= '{valid: issue, last: issue_last};
        end
    end

    assign ch_ctl[0]    = rd_ctl_reg;
    assign ch_idx[0]    = rd_idx_reg;
    assign ch_colour[0] = rd_data_reg;
    assign ch_dist[0]   = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        nplut_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (load),
            .point     (pt[k]),
            .in_ctl    (ch_ctl[k]),
            .in_idx    (ch_idx[k]),
            .in_colour (ch_colour[k]),
            .in_dist   (ch_dist[k]),
            .out_ctl   (ch_ctl[k+1]),
            .out_idx   (ch_idx[k+1]),
            .out_colour(ch_colour[k+1]),
            .out_dist  (ch_dist[k+1])
        );
    end

    assign better = first_reg || (ch_dist[NUM_CELLS] < best_dist_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        first_next     = first_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        best_col_next  = best_col_reg;
        res_stat_next  = res_stat_reg;
        res_idx_next   = res_idx_reg;
        res_col_next   = res_col_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // nearest-match tracker at the end of the chain
        if (ch_ctl[NUM_CELLS].valid) begin
            first_next = 1'b0;
            if (better) begin
                best_dist_next = ch_dist[NUM_CELLS];
                best_idx_next  = ch_idx[NUM_CELLS];
                best_col_next  = ch_colour[NUM_CELLS];
            end
            if (ch_ctl[NUM_CELLS].last) begin
                res_idx_next = best_idx_next;
                res_col_next = best_col_next;
                state_next   = ST_DONE;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_stat_next = STAT_OK;
                    res_idx_next  = '0;
                    res_col_next  = '0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    state_next    = ST_DONE;
                    unique case (in_op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            if (count_reg == CNT_W'(MAX_COLOURS)) begin
                                res_stat_next = STAT_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            res_x_next = {in_cb, in_cg[3:2]};
                            res_y_next = {in_cg[1:0], in_cr};
                            if (count_reg == '0) begin
                                res_stat_next = STAT_EMPTY;
                            end else begin
                                addr_next  = '0;
                                first_next = 1'b1;
                                state_next = ST_ISSUE;
                            end
                        end
                        default: begin
                            res_stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                addr_next = IDX_W'(addr_reg + IDX_W'(1));
                if (issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_stat_reg;
                    m_data_next  = {4'b0000, res_y_reg, res_x_reg,
                                    res_col_reg[7:0], res_col_reg[15:8],
                                    res_col_reg[23:16], 8'(res_idx_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg      <= addr_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        best_col_reg  <= best_col_next;
        res_stat_reg  <= res_stat_next;
        res_idx_reg   <= res_idx_next;
        res_col_reg   <= res_col_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
